>>> rtl/hlpr_pkg.sv
// Shared types, codes and character helpers for the hex line packet replay parser.
// No dependencies.
package hlpr_pkg;

  localparam int LEN_W = 7;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_DROP   = 2'd1;
  localparam logic [1:0] KIND_REFUSE = 2'd2;

  localparam logic [1:0] REASON_NONE     = 2'd0;
  localparam logic [1:0] REASON_NO_COLON = 2'd1;
  localparam logic [1:0] REASON_SHORT    = 2'd2;
  localparam logic [1:0] REASON_FRAMING  = 2'd3;

  localparam logic [1:0] JOB_EMIT   = 2'd0;
  localparam logic [1:0] JOB_DROP   = 2'd1;
  localparam logic [1:0] JOB_REFUSE = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_LO_H  = 8'h68;

  localparam logic [7:0] FRAME_HEAD = 8'hAA;
  localparam logic [7:0] FRAME_TAIL = 8'hAB;
  localparam int         MIN_PACKET = 6;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [1:0]  drop_reason;
    logic [31:0] packets_sent;
  } result_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       reason;
    logic [LEN_W-1:0] len;
  } job_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    return v;
  endfunction

  function automatic logic [7:0] prefix_char(input logic is_pkt, input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = is_pkt ? 8'h50 : 8'h68;
      2'd1:    c = is_pkt ? 8'h4B : 8'h65;
      2'd2:    c = is_pkt ? 8'h54 : 8'h78;
      default: c = is_pkt ? 8'h3A : 8'h3D;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/hlpr_front.sv
// Front end: accepts characters and ticks, parses lines, fills the packet store
// and queues emit/drop/refuse jobs. Depends on hlpr_pkg.
module hlpr_front
  import hlpr_pkg::*;
#(
  parameter int MAX_PACKET    = 64,
  parameter int LINE_CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable_we,
  input  logic                          enable_wdata,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  item_t                         item,
  input  logic                          q_full,
  output logic                          push,
  output job_t                          push_job,
  input  logic                          emit_done,
  output logic                          wr_en,
  output logic [$clog2(MAX_PACKET)-1:0] wr_addr,
  output logic [7:0]                    wr_data
);

  localparam int IDX_W = $clog2(MAX_PACKET);
  localparam int PL_W  = $clog2(MAX_PACKET + 1);
  localparam int LC_W  = $clog2(LINE_CAPACITY);
  localparam logic [PL_W-1:0] PL_MAX  = PL_W'(MAX_PACKET);
  localparam logic [PL_W-1:0] PL_MIN  = PL_W'(MIN_PACKET);
  localparam logic [LC_W-1:0] LC_LAST = LC_W'(LINE_CAPACITY - 1);

  localparam logic [3:0] PH_START    = 4'd0;
  localparam logic [3:0] PH_IGNORE   = 4'd1;
  localparam logic [3:0] PH_PFX_PKT  = 4'd2;
  localparam logic [3:0] PH_PFX_HEX  = 4'd3;
  localparam logic [3:0] PH_DLY_WS   = 4'd4;
  localparam logic [3:0] PH_DLY_DIG  = 4'd5;
  localparam logic [3:0] PH_DLY_SEEK = 4'd6;
  localparam logic [3:0] PH_BLANK    = 4'd7;
  localparam logic [3:0] PH_HEX_HI   = 4'd8;
  localparam logic [3:0] PH_HEX_LO   = 4'd9;
  localparam logic [3:0] PH_HEX_END  = 4'd10;

  logic            enable, enable_next;
  logic [LC_W-1:0] line_count, line_count_next;
  logic [3:0]      phase, phase_next;
  logic [2:0]      prog, prog_next;
  logic [31:0]     delay_value, delay_value_next;
  logic [32:0]     delay_acc, delay_acc_next;
  logic            delay_neg, delay_neg_next;
  logic [3:0]      high_nib, high_nib_next;
  logic [PL_W-1:0] plen, plen_next;
  logic            content_ended, content_ended_next;
  logic            pending, pending_next;
  logic [31:0]     elapsed, elapsed_next;
  logic            emit_busy, emit_busy_next;
  logic [7:0]      first_b, first_b_next;
  logic [7:0]      last_b, last_b_next;

  logic        accept, do_clear, is_data, is_blank, is_pkt;
  logic [3:0]  in_ph;
  logic [7:0]  c;
  logic [4:0]  hv;
  logic [3:0]  dig;
  logic [36:0] acc_mul;
  logic [31:0] elapsed_inc;

  assign item_stall = emit_busy || q_full;
  assign accept     = item_valid && !item_stall;
  assign c          = item.char_byte;
  assign hv         = hex_val(c);
  assign dig        = c[3:0];
  assign is_blank   = (c == CH_SPACE) || (c == CH_TAB);
  assign is_pkt     = (phase == PH_PFX_PKT);
  assign acc_mul    = ({4'b0, delay_acc} << 3) + ({4'b0, delay_acc} << 1) + 37'(dig);
  assign elapsed_inc = elapsed + 32'd1;

  always_comb begin
    enable_next        = enable;
    line_count_next    = line_count;
    phase_next         = phase;
    prog_next          = prog;
    delay_value_next   = delay_value;
    delay_acc_next     = delay_acc;
    delay_neg_next     = delay_neg;
    high_nib_next      = high_nib;
    plen_next          = plen;
    content_ended_next = content_ended;
    pending_next       = pending;
    elapsed_next       = elapsed;
    emit_busy_next     = emit_busy;
    first_b_next       = first_b;
    last_b_next        = last_b;
    do_clear           = 1'b0;
    is_data            = 1'b0;
    in_ph              = phase;
    push               = 1'b0;
    push_job.kind      = JOB_DROP;
    push_job.reason    = REASON_NONE;
    push_job.len       = LEN_W'(plen);
    wr_en              = 1'b0;
    wr_addr            = plen[IDX_W-1:0];
    wr_data            = {high_nib, hv[3:0]};

    if (emit_done) emit_busy_next = 1'b0;

    if (accept && enable) begin
      if (item.cmd) begin
        if (pending) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= delay_value) begin
            pending_next   = 1'b0;
            push           = 1'b1;
            push_job.kind  = JOB_EMIT;
            emit_busy_next = 1'b1;
            do_clear       = 1'b1;
          end
        end
      end else if (pending) begin
        push          = 1'b1;
        push_job.kind = JOB_REFUSE;
      end else if (c == CH_LF || c == CH_CR) begin
        if (line_count != '0) begin
          do_clear = 1'b1;
          if (phase == PH_DLY_WS || phase == PH_DLY_DIG || phase == PH_DLY_SEEK) begin
            push            = 1'b1;
            push_job.reason = REASON_NO_COLON;
          end else if (phase >= PH_BLANK && phase <= PH_HEX_END && plen != '0) begin
            if (plen < PL_MIN) begin
              push            = 1'b1;
              push_job.reason = REASON_SHORT;
            end else if (first_b != FRAME_HEAD || last_b != FRAME_TAIL) begin
              push            = 1'b1;
              push_job.reason = REASON_FRAMING;
            end else if (delay_value != '0) begin
              // hold packet, start the tick count
              do_clear           = 1'b0;
              pending_next       = 1'b1;
              elapsed_next       = '0;
              line_count_next    = '0;
              phase_next         = PH_START;
              content_ended_next = 1'b0;
            end else begin
              push           = 1'b1;
              push_job.kind  = JOB_EMIT;
              emit_busy_next = 1'b1;
            end
          end
        end
      end else if (line_count < LC_LAST) begin
        line_count_next = line_count + 1'b1;
        if (!content_ended) begin
          if (c == CH_NUL) begin
            if (phase == PH_START || phase == PH_PFX_PKT || phase == PH_PFX_HEX)
              phase_next = PH_IGNORE;
            else
              content_ended_next = 1'b1;
          end else begin
            case (phase)
              PH_START: begin
                if (c == CH_HASH) phase_next = PH_IGNORE;
                else if (c == CH_UP_P) begin
                  phase_next = PH_PFX_PKT;
                  prog_next  = 3'd1;
                end else if (c == CH_LO_H) begin
                  phase_next = PH_PFX_HEX;
                  prog_next  = 3'd1;
                end else begin
                  is_data = 1'b1;
                  in_ph   = PH_BLANK;
                end
              end
              PH_PFX_PKT, PH_PFX_HEX: begin
                if (c != prefix_char(is_pkt, prog[1:0])) phase_next = PH_IGNORE;
                else begin
                  prog_next = {1'b0, prog[1:0]} + 3'd1;
                  if (prog[1:0] == 2'd3) phase_next = is_pkt ? PH_DLY_WS : PH_BLANK;
                end
              end
              PH_DLY_WS: begin
                if (c == CH_COLON) phase_next = PH_BLANK;
                else if (is_blank || c == CH_VT || c == CH_FF) phase_next = PH_DLY_WS;
                else if (c == CH_PLUS || c == CH_MINUS) begin
                  delay_neg_next = (c == CH_MINUS);
                  phase_next     = PH_DLY_DIG;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                  delay_acc_next = 33'(dig);
                  phase_next     = PH_DLY_DIG;
                end else phase_next = PH_DLY_SEEK;
              end
              PH_DLY_DIG: begin
                if (c == CH_COLON) phase_next = PH_BLANK;
                else if (c >= CH_ZERO && c <= CH_NINE) begin
                  if (acc_mul > 37'h0_FFFF_FFFF) delay_acc_next = 33'h1_0000_0000;
                  else delay_acc_next = acc_mul[32:0];
                end else phase_next = PH_DLY_SEEK;
              end
              PH_DLY_SEEK: begin
                if (c == CH_COLON) phase_next = PH_BLANK;
              end
              PH_BLANK, PH_HEX_HI, PH_HEX_LO: is_data = 1'b1;
              default: ;
            endcase
            // colon closes the delay field
            if (c == CH_COLON &&
                (phase == PH_DLY_WS || phase == PH_DLY_DIG || phase == PH_DLY_SEEK)) begin
              if (delay_acc[32]) delay_value_next = '1;
              else if (delay_neg) delay_value_next = 32'd0 - delay_acc[31:0];
              else delay_value_next = delay_acc[31:0];
            end
            if (is_data) begin
              if (in_ph == PH_BLANK && is_blank) phase_next = PH_BLANK;
              else if (in_ph == PH_HEX_LO) begin
                if (hv[4] || plen >= PL_MAX) phase_next = PH_HEX_END;
                else begin
                  wr_en       = 1'b1;
                  last_b_next = wr_data;
                  if (plen == '0) first_b_next = wr_data;
                  plen_next  = plen + 1'b1;
                  phase_next = (plen + 1'b1 >= PL_MAX) ? PH_HEX_END : PH_HEX_HI;
                end
              end else begin
                if (hv[4]) phase_next = PH_HEX_END;
                else begin
                  high_nib_next = hv[3:0];
                  phase_next    = PH_HEX_LO;
                end
              end
            end
          end
        end
      end
    end

    if (enable_we && enable_wdata != enable) begin
      enable_next = enable_wdata;
      if (enable_wdata) begin
        do_clear     = 1'b1;
        pending_next = 1'b0;
        elapsed_next = '0;
      end
    end

    if (do_clear) begin
      line_count_next    = '0;
      phase_next         = PH_START;
      prog_next          = '0;
      delay_value_next   = '0;
      delay_acc_next     = '0;
      delay_neg_next     = 1'b0;
      high_nib_next      = '0;
      plen_next          = '0;
      content_ended_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      line_count    <= '0;
      phase         <= PH_START;
      prog          <= '0;
      delay_value   <= '0;
      delay_acc     <= '0;
      delay_neg     <= 1'b0;
      high_nib      <= '0;
      plen          <= '0;
      content_ended <= 1'b0;
      pending       <= 1'b0;
      elapsed       <= '0;
      emit_busy     <= 1'b0;
      first_b       <= '0;
      last_b        <= '0;
    end else begin
      enable        <= enable_next;
      line_count    <= line_count_next;
      phase         <= phase_next;
      prog          <= prog_next;
      delay_value   <= delay_value_next;
      delay_acc     <= delay_acc_next;
      delay_neg     <= delay_neg_next;
      high_nib      <= high_nib_next;
      plen          <= plen_next;
      content_ended <= content_ended_next;
      pending       <= pending_next;
      elapsed       <= elapsed_next;
      emit_busy     <= emit_busy_next;
      first_b       <= first_b_next;
      last_b        <= last_b_next;
    end
  end

  a_no_pending_while_emit: assert property (@(posedge clk) disable iff (rst)
    !(pending && emit_busy)) else $error("pending packet during replay");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    plen <= PL_MAX) else $error("packet length overrun");
  a_no_store_write_in_replay: assert property (@(posedge clk) disable iff (rst)
    emit_busy |-> !wr_en) else $error("store written during replay");

endmodule

>>> rtl/hlpr_queue.sv
// Two-entry job queue between front and back end.
// Depends on hlpr_pkg.
module hlpr_queue
  import hlpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t       entries [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("job queue underflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> !empty) else $error("pushed job lost");

endmodule

>>> rtl/hlpr_back.sv
// Back end: packet store, result register and byte replay of queued jobs.
// Depends on hlpr_pkg.
module hlpr_back
  import hlpr_pkg::*;
#(
  parameter int MAX_PACKET = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_PACKET)-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic                          q_empty,
  input  job_t                          head,
  output logic                          pop,
  output logic                          emit_done,
  output logic                          result_valid,
  input  logic                          result_stall,
  output result_t                       result
);

  localparam int IDX_W = $clog2(MAX_PACKET);
  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EMIT = 1'b1;

  logic [7:0]       store [MAX_PACKET];
  logic [7:0]       rd_q;
  logic [0:0]       state;
  logic [IDX_W-1:0] idx, idx_next;
  logic [LEN_W-1:0] len;
  logic [31:0]      count;
  logic             load, last;

  assign load      = !result_valid || !result_stall;
  assign pop       = (state == ST_IDLE) && !q_empty && load;
  assign last      = (LEN_W'(idx) + 1'b1) == len;
  assign emit_done = (state == ST_EMIT) && load && last;

  always_comb begin
    if (state == ST_EMIT) begin
      if (load && !last) idx_next = idx + 1'b1;
      else if (load) idx_next = '0;
      else idx_next = idx;
    end else begin
      idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    rd_q <= store[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      count        <= '0;
      idx          <= '0;
      len          <= '0;
    end else begin
      idx <= idx_next;
      if (load) result_valid <= 1'b0;
      if (pop) begin
        result.packet_byte  <= '0;
        result.last_byte    <= 1'b0;
        result.packets_sent <= count;
        case (head.kind)
          JOB_EMIT: begin
            count <= count + 32'd1;
            len   <= head.len;
            state <= ST_EMIT;
          end
          JOB_DROP: begin
            result_valid       <= 1'b1;
            result.kind        <= KIND_DROP;
            result.drop_reason <= head.reason;
          end
          JOB_REFUSE: begin
            result_valid       <= 1'b1;
            result.kind        <= KIND_REFUSE;
            result.drop_reason <= REASON_NONE;
          end
          default: ;
        endcase
      end
      if (state == ST_EMIT && load) begin
        result_valid        <= 1'b1;
        result.kind         <= KIND_BYTE;
        result.packet_byte  <= rd_q;
        result.last_byte    <= last;
        result.drop_reason  <= REASON_NONE;
        result.packets_sent <= count;
        if (last) state <= ST_IDLE;
      end
    end
  end

  a_done_shows_last: assert property (@(posedge clk) disable iff (rst)
    emit_done |=> result_valid && result.last_byte && result.kind == KIND_BYTE)
    else $error("replay end without last byte");
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (LEN_W'(idx) < len)) else $error("replay index past length");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == JOB_EMIT) |=> count == $past(count) + 32'd1)
    else $error("packet counter missed a packet");

endmodule

>>> rtl/hex_line_packet_replay_parser.sv
// Hex line packet replay parser: characters or millisecond ticks in, packet bytes and
// line status out. A character or tick that causes at most one result is taken while no
// replay runs and the job queue has room; a drop or refuse result waits in a two-job queue
// while input goes on. A line that emits a packet holds the input while the back end
// replays the packet store one byte per cycle through the result register; a slow
// result side stretches the hold further. There is no clearing pass after reset.
// Top level; depends on hlpr_pkg, hlpr_front, hlpr_queue and hlpr_back.
module hex_line_packet_replay_parser
  import hlpr_pkg::*;
#(
  parameter int MAX_PACKET    = 64,
  parameter int LINE_CAPACITY = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    enable_we,
  input  logic    enable_wdata,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IDX_W = $clog2(MAX_PACKET);

  logic             q_full, q_empty, push, pop, emit_done, wr_en;
  job_t             push_job, head;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  hlpr_front #(
    .MAX_PACKET   (MAX_PACKET),
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .enable_we   (enable_we),
    .enable_wdata(enable_wdata),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job),
    .emit_done   (emit_done),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  hlpr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  hlpr_back #(
    .MAX_PACKET(MAX_PACKET)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .emit_done   (emit_done),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule
